// File: hw/rtl/wrm_pkg.sv
package wrm_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_K      = 16;
  localparam int DEF_PIXEL_BITS = 16;
  localparam int HEIGHT_LIMIT   = 1024;

  localparam int OUT_BITS  = 16;
  localparam int CFG_BITS  = 11;
  localparam int IDX_BITS  = 8;
  localparam int HGT_BITS  = 11;

  typedef enum logic [IDX_BITS-1:0] {
    REG_WINDOW_SIZE  = 8'd0,
    REG_IMAGE_WIDTH  = 8'd1,
    REG_IMAGE_HEIGHT = 8'd2
  } reg_index_t;

  localparam logic [4:0]  RST_WINDOW_SIZE  = 5'd2;
  localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd1024;
  localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd1024;

endpackage

// File: hw/rtl/wrm_front.sv
module wrm_front import wrm_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_K      = DEF_MAX_K,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int WW = $clog2(MAX_WIDTH + 1),
  localparam int SW = $clog2(MAX_K),
  localparam int KW = $clog2(MAX_K + 1),
  localparam int DW = PIXEL_BITS + CW + SW + KW + 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  restart,
  input  logic [KW-1:0]         k,
  input  logic [WW-1:0]         w,
  input  logic [HGT_BITS-1:0]   h,
  input  logic [PIXEL_BITS-1:0] pixel,
  input  logic                  push,
  output logic                  full,
  output logic                  q_push,
  output logic [DW-1:0]         q_data,
  input  logic                  q_full
);

  localparam int RW = $clog2(HEIGHT_LIMIT);

  logic [CW-1:0] col;
  logic [RW-1:0] row;
  logic [SW-1:0] slot;
  logic          col_end, row_end, win, last;
  logic [KW-1:0] hcount;

  assign full    = q_full;
  assign q_push  = push && !q_full;
  assign col_end = (32'(col) == 32'(w) - 1);
  assign row_end = (32'(row) == 32'(h) - 1);
  assign last    = col_end && row_end;
  assign win     = (32'(col) + 1 >= 32'(k)) && (32'(row) + 1 >= 32'(k));
  assign hcount  = (32'(col) + 1 < 32'(k)) ? KW'(32'(col) + 1) : k;
  assign q_data  = {pixel, col, slot, hcount, win, last};

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col  <= '0;
      row  <= '0;
      slot <= '0;
    end else if (q_push) begin
      if (col_end) begin
        col <= '0;
        if (row_end) begin
          row  <= '0;
          slot <= '0;
        end else begin
          row  <= row + 1'b1;
          slot <= (32'(slot) == 32'(k) - 1) ? '0 : slot + 1'b1;
        end
      end else begin
        col <= col + 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/wrm_queue.sv
module wrm_queue import wrm_pkg::*; #(
  parameter int DW = 8,
  parameter int DEPTH = 4,
  localparam int AW = $clog2(DEPTH),
  localparam int CNTW = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  logic [DW-1:0] wdata,
  output logic          full,
  input  logic          rd,
  output logic [DW-1:0] rdata,
  output logic          empty
);

  logic [DW-1:0]   mem [DEPTH];
  logic [AW-1:0]   wp, rp;
  logic [CNTW-1:0] cnt;
  logic            do_wr, do_rd;

  assign full  = (32'(cnt) == DEPTH);
  assign empty = (cnt == '0);
  assign do_wr = wr && !full;
  assign do_rd = rd && !empty;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (do_wr) mem[wp] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (do_wr) wp <= (32'(wp) == DEPTH - 1) ? '0 : wp + 1'b1;
      if (do_rd) rp <= (32'(rp) == DEPTH - 1) ? '0 : rp + 1'b1;
      cnt <= CNTW'(32'(cnt) + 32'(do_wr) - 32'(do_rd));
    end
  end

endmodule

// File: hw/rtl/wrm_back.sv
module wrm_back import wrm_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_K      = DEF_MAX_K,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS,
  localparam int CW = $clog2(MAX_WIDTH),
  localparam int SW = $clog2(MAX_K),
  localparam int KW = $clog2(MAX_K + 1),
  localparam int DW = PIXEL_BITS + CW + SW + KW + 2,
  localparam int DEPTH = MAX_K * MAX_WIDTH,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                restart,
  input  logic [KW-1:0]       k,
  input  logic [DW-1:0]       q_data,
  input  logic                q_empty,
  output logic                q_pop,
  output logic [OUT_BITS-1:0] min_range,
  output logic                any_window,
  output logic                empty,
  input  logic                pop
);

  localparam int PB = PIXEL_BITS;

  typedef enum logic [2:0] {S_IDLE, S_HSCAN, S_WRITE, S_VRD, S_VCMP, S_RES} state_t;

  state_t        state;
  logic [PB-1:0] rw [MAX_K];
  logic [PB-1:0] hmin_mem [DEPTH];
  logic [PB-1:0] hmax_mem [DEPTH];
  logic [PB-1:0] rd_min, rd_max;
  logic [AW-1:0] rd_addr;
  logic [PB-1:0] vmn, vmx, best;
  logic          seen;
  logic [CW-1:0] col;
  logic [SW-1:0] slot, vslot;
  logic [KW-1:0] hn, hi, vr;
  logic          win, last;
  logic          res_valid;
  logic [OUT_BITS-1:0] res_min;
  logic          res_any;

  logic [PB-1:0] q_pixel;
  logic [CW-1:0] q_col;
  logic [SW-1:0] q_slot;
  logic [KW-1:0] q_hn;
  logic          q_win, q_last;
  logic [PB-1:0] range, best_upd;
  logic          seen_upd, res_free, res_load;
  logic [AW-1:0] wr_addr;
  logic [SW-1:0] vslot_next;
  logic [SW-1:0] prev_slot;

  assign {q_pixel, q_col, q_slot, q_hn, q_win, q_last} = q_data;
  assign q_pop      = (state == S_IDLE) && !q_empty;
  assign range      = vmx - vmn;
  assign best_upd   = (win && range < best) ? range : best;
  assign seen_upd   = seen | win;
  assign res_free   = !res_valid || pop;
  assign res_load   = (state == S_RES) && last && res_free;
  assign wr_addr    = AW'(32'(slot) * MAX_WIDTH + 32'(col));
  assign prev_slot  = (slot == '0) ? SW'(32'(k) - 1) : slot - 1'b1;
  assign vslot_next = (vslot == '0) ? SW'(32'(k) - 1) : vslot - 1'b1;
  assign empty      = !res_valid;
  assign min_range  = res_min;
  assign any_window = res_any;

  always_ff @(posedge clk) begin
    if (state == S_WRITE) begin
      hmin_mem[wr_addr] <= vmn;
      hmax_mem[wr_addr] <= vmx;
    end
    rd_min <= hmin_mem[rd_addr];
    rd_max <= hmax_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state     <= S_IDLE;
      best      <= '1;
      seen      <= 1'b0;
      res_valid <= 1'b0;
      for (int i = 0; i < MAX_K; i++) rw[i] <= '0;
    end else begin
      if (pop && res_valid && !res_load) res_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            rw[0] <= q_pixel;
            for (int i = 1; i < MAX_K; i++) rw[i] <= rw[i-1];
            vmn   <= q_pixel;
            vmx   <= q_pixel;
            col   <= q_col;
            slot  <= q_slot;
            hn    <= q_hn;
            win   <= q_win;
            last  <= q_last;
            hi    <= KW'(1);
            state <= S_HSCAN;
          end
        end
        S_HSCAN: begin
          if (hi < hn) begin
            if (rw[hi[SW-1:0]] < vmn) vmn <= rw[hi[SW-1:0]];
            if (rw[hi[SW-1:0]] > vmx) vmx <= rw[hi[SW-1:0]];
            hi <= hi + 1'b1;
          end else begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          vslot   <= prev_slot;
          rd_addr <= AW'(32'(prev_slot) * MAX_WIDTH + 32'(col));
          vr      <= KW'(1);
          if (win && 32'(k) > 1) state <= S_VRD;
          else if (win || last) state <= S_RES;
          else state <= S_IDLE;
        end
        S_VRD: state <= S_VCMP;
        S_VCMP: begin
          if (rd_min < vmn) vmn <= rd_min;
          if (rd_max > vmx) vmx <= rd_max;
          if (32'(vr) == 32'(k) - 1) begin
            state <= S_RES;
          end else begin
            vr      <= vr + 1'b1;
            vslot   <= vslot_next;
            rd_addr <= AW'(32'(vslot_next) * MAX_WIDTH + 32'(col));
            state   <= S_VRD;
          end
        end
        S_RES: begin
          if (!last) begin
            best  <= best_upd;
            seen  <= seen_upd;
            state <= S_IDLE;
          end else if (res_free) begin
            // emit frame result and start a new frame
            res_valid <= 1'b1;
            res_min   <= seen_upd ? OUT_BITS'(best_upd) : '0;
            res_any   <= seen_upd;
            best      <= '1;
            seen      <= 1'b0;
            for (int i = 0; i < MAX_K; i++) rw[i] <= '0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_vcmp_after_vrd: assert property (@(posedge clk) disable iff (rst)
    state == S_VCMP |-> $past(state) == S_VRD) else $error("compare without read");
  a_res_from_res: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(state) == S_RES) else $error("result outside result step");
  a_hscan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_HSCAN |-> hi <= hn) else $error("row scan overran");
  a_vr_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_VCMP |-> 32'(vr) < 32'(k)) else $error("column scan overran");

endmodule

// File: hw/rtl/window_range_min_2d.sv
// Channel   Direction  Handshake           Payload
// pixel     in         push / full         pixel
// result    out        pop / empty         min_range, any_window
// config    in         cfg_valid/cfg_ready cfg_index, cfg_data
//
// A pixel that ends a full window passes, in the back sequencer, a row scan of the shift
// line over n = min(column+1, K) pixels, a write step, a column scan of K-1 rows through
// the single read port of the line stores (a read and a compare step each), a result step.
// Other pixels skip the column scan; of them only a frame's last takes the result step.
// Reset (rst, synchronous) clears counters, window and result; line stores are not
// cleared. A four-entry queue parts front and back, and a held result stalls only the
// last pixel of the next frame.
module window_range_min_2d import wrm_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_K      = DEF_MAX_K,
  parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [PIXEL_BITS-1:0] pixel,
  input  logic                  push,
  output logic                  full,
  output logic [OUT_BITS-1:0]   min_range,
  output logic                  any_window,
  output logic                  empty,
  input  logic                  pop,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [IDX_BITS-1:0]   cfg_index,
  input  logic [CFG_BITS-1:0]   cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);
  localparam int SW = $clog2(MAX_K);
  localparam int KW = $clog2(MAX_K + 1);
  localparam int DW = PIXEL_BITS + CW + SW + KW + 2;

  logic [4:0]          window_size;
  logic [10:0]         image_width, image_height;
  logic                restart, cfg_we;
  logic [KW-1:0]       k;
  logic [WW-1:0]       w;
  logic [HGT_BITS-1:0] h;
  logic                q_push, q_full, q_pop, q_empty;
  logic [DW-1:0]       q_wdata, q_rdata;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign restart   = cfg_we && (cfg_index == REG_WINDOW_SIZE || cfg_index == REG_IMAGE_WIDTH
                                || cfg_index == REG_IMAGE_HEIGHT);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size  <= RST_WINDOW_SIZE;
      image_width  <= RST_IMAGE_WIDTH;
      image_height <= RST_IMAGE_HEIGHT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_WINDOW_SIZE:  window_size  <= cfg_data[4:0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data;
        REG_IMAGE_HEIGHT: image_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // clamp registers into their working ranges
  assign k = (window_size == '0) ? KW'(1) :
             (32'(window_size) > MAX_K) ? KW'(MAX_K) : KW'(window_size);
  assign w = (image_width == '0) ? WW'(1) :
             (32'(image_width) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(image_width);
  assign h = (image_height == '0) ? HGT_BITS'(1) :
             (32'(image_height) > HEIGHT_LIMIT) ? HGT_BITS'(HEIGHT_LIMIT) : image_height;

  wrm_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_K(MAX_K), .PIXEL_BITS(PIXEL_BITS)) u_front (
    .clk, .rst, .restart, .k, .w, .h, .pixel, .push, .full,
    .q_push, .q_data(q_wdata), .q_full
  );

  wrm_queue #(.DW(DW), .DEPTH(4)) u_queue (
    .clk, .rst(rst || restart), .wr(q_push), .wdata(q_wdata), .full(q_full),
    .rd(q_pop), .rdata(q_rdata), .empty(q_empty)
  );

  wrm_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_K(MAX_K), .PIXEL_BITS(PIXEL_BITS)) u_back (
    .clk, .rst, .restart, .k, .q_data(q_rdata), .q_empty, .q_pop,
    .min_range, .any_window, .empty, .pop
  );

endmodule
